// ===== rtl/core/rv64_subset_instruction_executor_defines.svh =====
// ----------------------------------------------------------------------------
// RV64 subset executor assertion macros
// Shared concurrent assertion forms; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RV64_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define RV64_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property with reset disable.
`define RVX_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds across reset.
`define RVX_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVX_ASSERT(name, clk, rst_n, prop, msg)
`define RVX_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

// ===== rtl/core/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// RV64 subset executor package
// Opcodes, sizes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;
  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 32;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int NUM_CNT   = 7;

  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] F7_BASE    = 7'b0000000;
  localparam logic [6:0] F7_ALT     = 7'b0100000;
  localparam logic [6:0] F7_MULDIV  = 7'b0000001;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_UNSUPP   = 2'd1;
  localparam logic [1:0] FAULT_MISALIGN = 2'd2;

  localparam logic [2:0] CFG_START_PC  = 3'd0;
  localparam logic [2:0] CFG_ARG_ZERO  = 3'd1;
  localparam logic [2:0] CFG_ARG_ONE   = 3'd2;
  localparam logic [2:0] CFG_ARG_TWO   = 3'd3;
  localparam logic [2:0] CFG_ARG_THREE = 3'd4;
  localparam logic [2:0] CFG_STACK_TOP = 3'd5;
  localparam logic [31:0] STACK_TOP_RST = 32'd8192;

  localparam logic [2:0] CNT_INSTR     = 3'd0;
  localparam logic [2:0] CNT_ALU       = 3'd1;
  localparam logic [2:0] CNT_LOAD      = 3'd2;
  localparam logic [2:0] CNT_STORE     = 3'd3;
  localparam logic [2:0] CNT_JUMP      = 3'd4;
  localparam logic [2:0] CNT_TAKEN     = 3'd5;
  localparam logic [2:0] CNT_NOT_TAKEN = 3'd6;

  localparam logic [REG_AW-1:0] REG_SP = REG_AW'(2);
  localparam logic [REG_AW-1:0] REG_A0 = REG_AW'(10);
  localparam logic [REG_AW-1:0] REG_A1 = REG_AW'(11);
  localparam logic [REG_AW-1:0] REG_A2 = REG_AW'(12);
  localparam logic [REG_AW-1:0] REG_A3 = REG_AW'(13);

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/rvx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/rvx_muldiv.sv =====
// ----------------------------------------------------------------------------
// RV64 subset executor multiply/divide unit
// Shared radix-2 unit: shift-add multiply or restoring signed divide.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_muldiv (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rvx_pkg::md_req_t req,
  input  wire logic [63:0]    op_a,
  input  wire logic [63:0]    op_b,
  output rvx_pkg::md_rsp_t    rsp,
  output logic      [63:0]    result
);
  import rvx_pkg::*;

  logic        busy_r, done_r, div_r, neg_r, dz_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r, opa_r, opb_r;
  logic [63:0] acc_nxt, opa_nxt, opb_nxt;
  logic [64:0] rem_sh, diff;

  // One bit per cycle.
  always_comb begin
    rem_sh  = {acc_r, opa_r[63]};
    diff    = rem_sh - {1'b0, opb_r};
    acc_nxt = acc_r;
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    if (div_r) begin
      if (!diff[64]) begin
        acc_nxt = diff[63:0];
        opa_nxt = {opa_r[62:0], 1'b1};
      end else begin
        acc_nxt = rem_sh[63:0];
        opa_nxt = {opa_r[62:0], 1'b0};
      end
    end else begin
      acc_nxt = acc_r + (opb_r[0] ? opa_r : 64'd0);
      opa_nxt = {opa_r[62:0], 1'b0};
      opb_nxt = {1'b0, opb_r[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      acc_r <= '0;
      neg_r <= op_a[63] ^ op_b[63];
      dz_r  <= (op_b == 64'd0);
      if (req.is_div) begin
        opa_r <= op_a[63] ? (64'd0 - op_a) : op_a;
        opb_r <= op_b[63] ? (64'd0 - op_b) : op_b;
      end else begin
        opa_r <= op_a;
        opb_r <= op_b;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
    end
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (!div_r) begin
      result = acc_r;
    end else if (dz_r) begin
      result = '1;
    end else begin
      result = neg_r ? (64'd0 - opa_r) : opa_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rv64_subset_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// RV64 subset instruction executor
// Multicycle core executing one instruction word per input item.
// ----------------------------------------------------------------------------
// Usage: each input item carries a kind bit on in_tuser (0 = start a run from
// the configuration registers, 1 = execute the word on in_tdata, fetched by
// the user from the last reported next_pc). Every item yields exactly one
// result item on out_tdata with the next PC, halt flag, fault code, the low
// word of a0 and the seven class counters.
// In order, an ALU, branch or jump item passes the accept, register read,
// execute and output states before its result is loaded. Loads and stores
// add a state for the data memory read. MUL and DIV wait in their own state
// for the 64 single-bit steps of the shared multiply/divide unit. A start
// item writes sp and a0..a3 in turn through the single register file write
// port. Items on a halted or faulted core go from acceptance straight to the
// output state. One item is in work at a time; in_tready is high only while
// the sequencer is idle.
// Reset clears the register file valid bits, PC, counters and fault code; the
// data memory holds no reset value and needs no clearing pass. When the
// receiver stalls, the result waits in the output register; the next item is
// still accepted and finishes up to its output stage, where it waits.
// Configuration writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv64_subset_instruction_executor_defines.svh"
module rv64_subset_instruction_executor (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: instr[31:0]
  input  wire logic [31:0]  in_tdata,
  // in_tuser: op[0]
  input  wire logic         in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata: next_pc[31:0], halted[32], fault[34:33], return_value[66:35],
  // instr_count[98:67], alu_count[130:99], load_count[162:131],
  // store_count[194:163], jump_count[226:195], taken_count[258:227],
  // not_taken_count[290:259], zero pad[295:291]
  output logic      [295:0] out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [63:0]  cfg_wdata
);
  import rvx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_EXEC, S_MD, S_MEM, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [31:0] start_pc_r, stack_top_r;
  logic [63:0] arg_zero_r, arg_one_r, arg_two_r, arg_three_r;

  // Architectural state.
  logic [31:0]         pc_r;
  logic [1:0]          fault_r;
  logic [31:0]         cnt_r [NUM_CNT];
  logic [NUM_REGS-1:0] rf_valid_r;
  logic [63:0]         a0_r;
  logic [31:0]         instr_r;
  logic [2:0]          step_r;

  // Values carried from execute to the memory stage.
  logic [MEM_AW-1:0] mem_idx_r;
  logic [2:0]        mem_off_r;
  logic [63:0]       st_data_r;

  logic [295:0] out_tdata_r;
  logic         out_tvalid_r;

  // Register file: two copies written together give two read ports.
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [63:0]       rf_wdata, rf_rdata1, rf_rdata2;

  logic              dm_we;
  logic [63:0]       dm_wdata, dm_rdata;
  logic [MEM_AW-1:0] mem_idx;

  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [63:0] md_result;

  // Instruction fields.
  logic [6:0]        opc, f7;
  logic [2:0]        f3;
  logic [REG_AW-1:0] rd, rs1, rs2;
  logic [63:0]       a, b, imm_i, imm_s, imm_b, imm_j, addr;
  logic [31:0]       pc_plus4;

  // Execute-stage decisions.
  logic [1:0]  ex_fault;
  logic        ex_wr, ex_md, ex_mem, ex_commit;
  logic [63:0] ex_val;
  logic [31:0] ex_next;
  logic [2:0]  ex_cls;

  logic [63:0] ld_sh, ld_val, st_mask;

  logic        out_free;
  logic        commit_en;
  logic [2:0]  commit_cls;
  logic [31:0] commit_next;

  assign opc      = instr_r[6:0];
  assign rd       = instr_r[11:7];
  assign f3       = instr_r[14:12];
  assign rs1      = instr_r[19:15];
  assign rs2      = instr_r[24:20];
  assign f7       = instr_r[31:25];
  assign a        = rf_valid_r[rs1] ? rf_rdata1 : 64'd0;
  assign b        = rf_valid_r[rs2] ? rf_rdata2 : 64'd0;
  assign imm_i    = {{52{instr_r[31]}}, instr_r[31:20]};
  assign imm_s    = {{52{instr_r[31]}}, instr_r[31:25], instr_r[11:7]};
  assign imm_b    = {{52{instr_r[31]}}, instr_r[7], instr_r[30:25], instr_r[11:8], 1'b0};
  assign imm_j    = {{44{instr_r[31]}}, instr_r[19:12], instr_r[20], instr_r[30:21], 1'b0};
  assign pc_plus4 = pc_r + 32'd4;
  assign addr     = a + ((opc == OPC_LOAD) ? imm_i : imm_s);
  assign mem_idx  = addr[3 +: MEM_AW];
  assign out_free = !out_tvalid_r || out_tready;

  // Decode and the combinational part of execution.
  always_comb begin
    ex_fault = FAULT_NONE;
    ex_wr    = 1'b0;
    ex_md    = 1'b0;
    ex_mem   = 1'b0;
    ex_val   = '0;
    ex_next  = pc_plus4;
    ex_cls   = CNT_ALU;
    case (opc)
      OPC_REG: begin
        ex_wr = 1'b1;
        if (f3 == 3'd0 && f7 == F7_BASE) begin
          ex_val = a + b;
        end else if (f3 == 3'd0 && f7 == F7_ALT) begin
          ex_val = a - b;
        end else if (f3 == 3'd0 && f7 == F7_MULDIV) begin
          ex_md = 1'b1;
        end else if (f3 == 3'd1 && f7 == F7_BASE) begin
          ex_val = a << b[5:0];
        end else if (f3 == 3'd5 && f7 == F7_BASE) begin
          ex_val = a >> b[5:0];
        end else if (f3 == 3'd7 && f7 == F7_BASE) begin
          ex_val = a & b;
        end else if (f3 == 3'd4 && f7 == F7_MULDIV) begin
          ex_md = 1'b1;
        end else begin
          ex_fault = FAULT_UNSUPP;
        end
      end
      OPC_IMM: begin
        ex_wr = 1'b1;
        if (f3 == 3'd0) begin
          ex_val = a + imm_i;
        end else if (f3 == 3'd1 && instr_r[31:26] == 6'd0) begin
          ex_val = a << instr_r[25:20];
        end else if (f3 == 3'd5 && instr_r[31:26] == 6'd0) begin
          ex_val = a >> instr_r[25:20];
        end else begin
          ex_fault = FAULT_UNSUPP;
        end
      end
      OPC_LOAD, OPC_STORE: begin
        ex_cls = (opc == OPC_LOAD) ? CNT_LOAD : CNT_STORE;
        if (f3[2]) begin
          ex_fault = FAULT_UNSUPP;
        end else if ((f3 == 3'd1 && addr[0]) ||
                     (f3 == 3'd2 && addr[1:0] != 2'd0) ||
                     (f3 == 3'd3 && addr[2:0] != 3'd0)) begin
          ex_fault = FAULT_MISALIGN;
        end else begin
          ex_mem = 1'b1;
        end
      end
      OPC_BRANCH: begin
        ex_cls = CNT_NOT_TAKEN;
        case (f3)
          3'd0: ex_cls = (a == b) ? CNT_TAKEN : CNT_NOT_TAKEN;
          3'd1: ex_cls = (a != b) ? CNT_TAKEN : CNT_NOT_TAKEN;
          3'd4: ex_cls = ($signed(a) < $signed(b)) ? CNT_TAKEN : CNT_NOT_TAKEN;
          3'd5: ex_cls = ($signed(a) < $signed(b)) ? CNT_NOT_TAKEN : CNT_TAKEN;
          default: ex_fault = FAULT_UNSUPP;
        endcase
        if (ex_cls == CNT_TAKEN) begin
          ex_next = pc_r + imm_b[31:0];
        end
      end
      OPC_JAL: begin
        ex_cls  = CNT_JUMP;
        ex_wr   = 1'b1;
        ex_val  = {32'd0, pc_plus4};
        ex_next = pc_r + imm_j[31:0];
      end
      OPC_JALR: begin
        ex_cls = CNT_JUMP;
        if (f3 != 3'd0) begin
          ex_fault = FAULT_UNSUPP;
        end else begin
          ex_wr   = 1'b1;
          ex_val  = {32'd0, pc_plus4};
          // Target bits 31..1 of rs1 + imm; the carry out of bit 0 is added in.
          ex_next = {a[31:1] + imm_i[31:1] + 31'(a[0] & imm_i[0]), 1'b0};
        end
      end
      default: ex_fault = FAULT_UNSUPP;
    endcase
    ex_commit = (ex_fault == FAULT_NONE) && !ex_md && !ex_mem;
  end

  // Load alignment and store merge.
  always_comb begin
    ld_sh = dm_rdata >> {mem_off_r, 3'b000};
    case (f3[1:0])
      2'd0: ld_val = {{56{ld_sh[7]}}, ld_sh[7:0]};
      2'd1: ld_val = {{48{ld_sh[15]}}, ld_sh[15:0]};
      2'd2: ld_val = {{32{ld_sh[31]}}, ld_sh[31:0]};
      default: ld_val = dm_rdata;
    endcase
    case (f3[1:0])
      2'd0: st_mask = 64'h0000_0000_0000_00FF << {mem_off_r, 3'b000};
      2'd1: st_mask = 64'h0000_0000_0000_FFFF << {mem_off_r, 3'b000};
      2'd2: st_mask = 64'h0000_0000_FFFF_FFFF << {mem_off_r, 3'b000};
      default: st_mask = '1;
    endcase
    dm_wdata = (dm_rdata & ~st_mask) | ((st_data_r << {mem_off_r, 3'b000}) & st_mask);
    dm_we    = (state_r == S_MEM) && (opc == OPC_STORE);
  end

  // Register file write port and commit selection.
  always_comb begin
    rf_we       = 1'b0;
    rf_waddr    = rd;
    rf_wdata    = ex_val;
    commit_en   = 1'b0;
    commit_cls  = ex_cls;
    commit_next = ex_next;
    case (state_r)
      S_START: begin
        rf_we = 1'b1;
        case (step_r)
          3'd0: begin
            rf_waddr = REG_SP;
            rf_wdata = {32'd0, stack_top_r};
          end
          3'd1: begin
            rf_waddr = REG_A0;
            rf_wdata = arg_zero_r;
          end
          3'd2: begin
            rf_waddr = REG_A1;
            rf_wdata = arg_one_r;
          end
          3'd3: begin
            rf_waddr = REG_A2;
            rf_wdata = arg_two_r;
          end
          default: begin
            rf_waddr = REG_A3;
            rf_wdata = arg_three_r;
          end
        endcase
      end
      S_EXEC: begin
        rf_we     = ex_commit && ex_wr && (rd != '0);
        commit_en = ex_commit;
      end
      S_MD: begin
        rf_we       = md_rsp.done && (rd != '0);
        rf_wdata    = md_result;
        commit_en   = md_rsp.done;
        commit_cls  = CNT_ALU;
        commit_next = pc_plus4;
      end
      S_MEM: begin
        rf_we       = (opc == OPC_LOAD) && (rd != '0);
        rf_wdata    = ld_val;
        commit_en   = 1'b1;
        commit_cls  = (opc == OPC_LOAD) ? CNT_LOAD : CNT_STORE;
        commit_next = pc_plus4;
      end
      default: rf_we = 1'b0;
    endcase
    md_req.start  = (state_r == S_EXEC) && ex_md && (ex_fault == FAULT_NONE);
    md_req.is_div = f3[2];
  end

  rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rs1), .rdata(rf_rdata1)
  );

  rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rs2), .rdata(rf_rdata2)
  );

  rvx_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(mem_idx_r), .wdata(dm_wdata),
    .raddr(mem_idx), .rdata(dm_rdata)
  );

  rvx_muldiv u_muldiv (
    .clk(clk), .rst_n(rst_n), .req(md_req), .op_a(a), .op_b(b),
    .rsp(md_rsp), .result(md_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r  <= '0;
      arg_zero_r  <= '0;
      arg_one_r   <= '0;
      arg_two_r   <= '0;
      arg_three_r <= '0;
      stack_top_r <= STACK_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_PC:  start_pc_r  <= cfg_wdata[31:0];
        CFG_ARG_ZERO:  arg_zero_r  <= cfg_wdata;
        CFG_ARG_ONE:   arg_one_r   <= cfg_wdata;
        CFG_ARG_TWO:   arg_two_r   <= cfg_wdata;
        CFG_ARG_THREE: arg_three_r <= cfg_wdata;
        CFG_STACK_TOP: stack_top_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer with architectural state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      fault_r      <= FAULT_NONE;
      rf_valid_r   <= '0;
      a0_r         <= '0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      // In the output state the result register is reloaded below instead.
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      if (rf_we) begin
        rf_valid_r[rf_waddr] <= 1'b1;
        if (rf_waddr == REG_A0) begin
          a0_r <= rf_wdata;
        end
      end
      if (commit_en) begin
        pc_r <= commit_next;
        for (int i = 0; i < NUM_CNT; i++) begin
          if (3'(i) == commit_cls || 3'(i) == CNT_INSTR) begin
            cnt_r[i] <= cnt_r[i] + 32'd1;
          end
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            instr_r <= in_tdata;
            if (!in_tuser) begin
              rf_valid_r <= '0;
              pc_r       <= start_pc_r;
              fault_r    <= FAULT_NONE;
              step_r     <= '0;
              for (int i = 0; i < NUM_CNT; i++) begin
                cnt_r[i] <= '0;
              end
              state_r <= S_START;
            end else if (fault_r != FAULT_NONE || pc_r == 32'd0) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_START: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd4) begin
            state_r <= S_OUT;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          mem_idx_r <= mem_idx;
          mem_off_r <= addr[2:0];
          st_data_r <= b;
          if (ex_fault != FAULT_NONE) begin
            fault_r <= ex_fault;
            state_r <= S_OUT;
          end else if (ex_md) begin
            state_r <= S_MD;
          end else if (ex_mem) begin
            state_r <= S_MEM;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MD: begin
          if (md_rsp.done) begin
            state_r <= S_OUT;
          end
        end
        S_MEM: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {5'd0, cnt_r[6], cnt_r[5], cnt_r[4], cnt_r[3], cnt_r[2],
                             cnt_r[1], cnt_r[0], a0_r[31:0], fault_r, (pc_r == 32'd0),
                             pc_r};
            state_r      <= S_IDLE;
          end else if (out_tready) begin
            out_tvalid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `RVX_ASSERT(a_md_blocks_input, clk, rst_n, md_rsp.busy |-> !in_tready, "input taken during mul/div")
  `RVX_ASSERT(a_accept_drops_ready, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "ready held after accept")
  `RVX_ASSERT(a_x0_never_valid, clk, rst_n, !rf_valid_r[0], "x0 was written")
  `RVX_ASSERT_NORST(a_reset_clears_out, clk, !rst_n |=> !out_tvalid_r, "result valid after reset")
endmodule
`default_nettype wire
